### hdl/asrm_pkg.sv
// Shared types, constants and trig tables for the annular sector row mask.
package asrm_pkg;

	localparam int MAX_WIDTH_DEF = 64;
	localparam logic [15:0] POST_HEIGHT_RST = 16'd256;
	localparam logic [6:0] GRID_WIDTH_RST = 7'd64;
	localparam int CFG_DATA_W = 16;
	localparam logic CFG_POST_HEIGHT = 1'b0;
	localparam logic CFG_GRID_WIDTH = 1'b1;

	// Q16 cotangent of 1 degree is below 2^22
	localparam int COT_W = 22;
	localparam int DIV_STEPS = COT_W;
	localparam logic [23:0] RADIUS_CAP = 24'hFFFFFF;

	localparam logic [63:0] COS_ONE_DEG = 64'd1073578288;
	localparam logic [63:0] SIN_ONE_DEG = 64'd18739379;
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] Q30_HALF = 64'd536870912;

	typedef logic [30:0] q30_t;
	typedef q30_t [0:45] q30_tab_t;

	// Rotate by one degree per step, rounded to Q30
	function automatic q30_tab_t gen_table(input bit want_sin);
		logic [63:0] c;
		logic [63:0] s;
		logic [63:0] cn;
		logic [63:0] sn;
		q30_tab_t tab;
		c = Q30_ONE;
		s = '0;
		for (int k = 0; k <= 45; k++) begin
			tab[k] = want_sin ? s[30:0] : c[30:0];
			cn = (c * COS_ONE_DEG - s * SIN_ONE_DEG + Q30_HALF) >> 30;
			sn = (s * COS_ONE_DEG + c * SIN_ONE_DEG + Q30_HALF) >> 30;
			c = cn;
			s = sn;
		end
		return tab;
	endfunction

	localparam q30_tab_t COS_TAB = gen_table(1'b0);
	localparam q30_tab_t SIN_TAB = gen_table(1'b1);

	// Division operands, in order
	typedef enum logic [1:0] {
		OP_ELEV_OUT,
		OP_ELEV_IN,
		OP_AZ_RIGHT,
		OP_AZ_LEFT
	} div_op_t;

	typedef enum logic [2:0] {
		R_MUL_OUT,
		R_SCALE_OUT,
		R_SQ_OUT,
		R_MUL_IN,
		R_SCALE_IN,
		R_SQ_IN
	} rad_op_t;

	typedef struct packed {
		logic load;
		logic div_init;
		logic div_step;
		logic div_store;
		div_op_t op;
		logic rad_en;
		rad_op_t rad_op;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic last;
	} sts_t;

endpackage

### hdl/asrm_if.sv
// Word channels for the annular sector row mask.
interface asrm_in_if;
	logic valid;
	logic ready;
	logic [7:0] first_azimuth;
	logic [6:0] first_elevation;
	logic [7:0] second_azimuth;
	logic [6:0] second_elevation;
	logic [7:0] row_number;
	modport source(output valid, first_azimuth, first_elevation, second_azimuth,
		second_elevation, row_number, input ready);
	modport sink(input valid, first_azimuth, first_elevation, second_azimuth,
		second_elevation, row_number, output ready);
endinterface

interface asrm_out_if;
	logic valid;
	logic ready;
	logic [5:0] column;
	logic inside_res;
	logic last_column;
	modport source(output valid, column, inside_res, last_column, input ready);
	modport sink(input valid, column, inside_res, last_column, output ready);
endinterface

### hdl/asrm_ctrl.sv
// Sequencer for the annular sector row mask.
module asrm_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input asrm_pkg::sts_t sts,
	output asrm_pkg::cmd_t cmd
);
	import asrm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_INIT,
		S_DIV_RUN,
		S_DIV_STORE,
		S_RADIUS,
		S_EMIT
	} state_t;

	state_t state_q;
	div_op_t op_q;
	rad_op_t rad_q;
	logic [4:0] it_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		cmd.rad_op = rad_q;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_DIV_INIT: cmd.div_init = 1'b1;
			S_DIV_RUN: cmd.div_step = 1'b1;
			S_DIV_STORE: cmd.div_store = 1'b1;
			S_RADIUS: begin
				cmd.rad_en = 1'b1;
				cmd.capture = (rad_q == R_SQ_IN) && !sts.n_zero;
			end
			S_EMIT: cmd.capture = out_ready && !sts.last;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_ELEV_OUT;
			rad_q <= R_MUL_OUT;
			it_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					op_q <= OP_ELEV_OUT;
					state_q <= S_DIV_INIT;
				end
				S_DIV_INIT: begin
					it_q <= '0;
					state_q <= S_DIV_RUN;
				end
				S_DIV_RUN: begin
					it_q <= it_q + 5'd1;
					if (it_q == 5'(DIV_STEPS - 1)) state_q <= S_DIV_STORE;
				end
				S_DIV_STORE: begin
					if (op_q == OP_AZ_LEFT) begin
						rad_q <= R_MUL_OUT;
						state_q <= S_RADIUS;
					end else begin
						op_q <= div_op_t'(op_q + 2'd1);
						state_q <= S_DIV_INIT;
					end
				end
				S_RADIUS: begin
					case (rad_q)
						R_MUL_OUT: rad_q <= R_SCALE_OUT;
						R_SCALE_OUT: rad_q <= R_SQ_OUT;
						R_SQ_OUT: rad_q <= R_MUL_IN;
						R_MUL_IN: rad_q <= R_SCALE_IN;
						R_SCALE_IN: rad_q <= R_SQ_IN;
						default: state_q <= sts.n_zero ? S_IDLE : S_EMIT;
					endcase
				end
				S_EMIT: if (out_ready && sts.last) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hdl/asrm_dpath.sv
// Datapath: config registers, cotangent divider, radius math, column test.
module asrm_dpath #(
	parameter int MAX_WIDTH = asrm_pkg::MAX_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [asrm_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic [7:0] first_azimuth,
	input logic [6:0] first_elevation,
	input logic [7:0] second_azimuth,
	input logic [6:0] second_elevation,
	input logic [7:0] row_number,
	input asrm_pkg::cmd_t cmd,
	output asrm_pkg::sts_t sts,
	output logic [5:0] column,
	output logic inside_res,
	output logic last_column
);
	import asrm_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int NW = $clog2(MAX_WIDTH + 1);

	logic [15:0] ph_q;
	logic [6:0] gw_q;
	logic [6:0] e_out_q, e_in_q;
	logic [7:0] a_r_q, a_l_q;
	logic [NW-1:0] n_q;
	logic signed [9:0] y_q;
	logic [XW-1:0] x_q;
	logic [COT_W-1:0] cot_out_q, cot_in_q, cot_r_q, cot_l_q;
	logic [30:0] sv_q;
	logic [31:0] rem_q;
	logic [COT_W-1:0] dq_q;
	logic [37:0] p_q;
	logic [23:0] r_q;
	logic [47:0] ro2_q, ri2_q;
	logic [16:0] ysq_q;

	// clamp and order the corners
	logic [7:0] a1, a2;
	logic [6:0] e1, e2;
	logic [NW-1:0] n_eff;
	always_comb begin
		a1 = (first_azimuth == 8'd0) ? 8'd1 : (first_azimuth > 8'd179) ? 8'd179 : first_azimuth;
		a2 = (second_azimuth == 8'd0) ? 8'd1 : (second_azimuth > 8'd179) ? 8'd179 : second_azimuth;
		e1 = (first_elevation == 7'd0) ? 7'd1 : (first_elevation > 7'd89) ? 7'd89 : first_elevation;
		e2 = (second_elevation == 7'd0) ? 7'd1 : (second_elevation > 7'd89) ? 7'd89 : second_elevation;
		n_eff = (gw_q > 7'(MAX_WIDTH)) ? NW'(MAX_WIDTH) : NW'(gw_q);
	end

	// divider operand: angle folded to 1..90, table lookup
	logic [7:0] a_sel;
	logic [6:0] k;
	logic [5:0] tidx;
	logic [30:0] cv, sv;
	logic [46:0] dividend;
	always_comb begin
		a_sel = (cmd.op == OP_AZ_RIGHT) ? a_r_q : a_l_q;
		case (cmd.op)
			OP_ELEV_OUT: k = e_out_q;
			OP_ELEV_IN: k = e_in_q;
			default: k = (a_sel < 8'd90) ? a_sel[6:0] : 7'(8'd180 - a_sel);
		endcase
		tidx = (k <= 7'd45) ? k[5:0] : 6'(7'd90 - k);
		cv = (k <= 7'd45) ? COS_TAB[tidx] : SIN_TAB[tidx];
		sv = (k <= 7'd45) ? SIN_TAB[tidx] : COS_TAB[tidx];
		dividend = {cv, 16'b0} + 47'(sv >> 1);
	end

	logic [31:0] trial;
	logic ge;
	assign trial = {rem_q[30:0], dq_q[COT_W-1]};
	assign ge = trial >= {1'b0, sv_q};

	// radius scale by ten with rounding, then saturate
	logic [42:0] scaled;
	logic [23:0] r_sat;
	logic [15:0] cot_mul_ph;
	always_comb begin
		scaled = {2'b0, p_q, 3'b0} + {4'b0, p_q, 1'b0} + 43'd32768;
		r_sat = (|scaled[42:40]) ? RADIUS_CAP : scaled[39:16];
		cot_mul_ph = ph_q;
	end

	// column test
	logic signed [22:0] right_s, left_s;
	logic [16:0] xsq;
	logic [32:0] d2;
	logic signed [31:0] yq, xr, xl;
	logic [NW:0] x_inc;
	always_comb begin
		right_s = (a_r_q > 8'd90) ? -$signed({1'b0, cot_r_q}) : $signed({1'b0, cot_r_q});
		left_s = (a_l_q > 8'd90) ? -$signed({1'b0, cot_l_q}) : $signed({1'b0, cot_l_q});
		xsq = 17'(x_q * x_q);
		d2 = {xsq + ysq_q, 16'b0};
		yq = $signed({{6{y_q[9]}}, y_q, 16'b0});
		xr = 32'($signed({1'b0, x_q})) * 32'(right_s);
		xl = 32'($signed({1'b0, x_q})) * 32'(left_s);
		x_inc = (NW+1)'(x_q) + (NW+1)'(1);
	end

	assign sts.n_zero = (n_q == '0);
	assign sts.last = last_column;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= POST_HEIGHT_RST;
			gw_q <= GRID_WIDTH_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_POST_HEIGHT) ph_q <= cfg_data;
			else gw_q <= cfg_data[6:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_out_q <= (e1 < e2) ? e1 : e2;
			e_in_q <= (e1 < e2) ? e2 : e1;
			a_r_q <= (a1 < a2) ? a1 : a2;
			a_l_q <= (a1 < a2) ? a2 : a1;
			n_q <= n_eff;
			y_q <= $signed({2'b0, row_number}) - $signed(10'(n_eff));
			x_q <= '0;
		end
		if (cmd.div_init) begin
			sv_q <= sv;
			rem_q <= 32'(dividend[46:COT_W]);
			dq_q <= dividend[COT_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q <= ge ? trial - {1'b0, sv_q} : trial;
			dq_q <= {dq_q[COT_W-2:0], ge};
		end
		if (cmd.div_store) begin
			case (cmd.op)
				OP_ELEV_OUT: cot_out_q <= dq_q;
				OP_ELEV_IN: cot_in_q <= dq_q;
				OP_AZ_RIGHT: cot_r_q <= dq_q;
				default: cot_l_q <= dq_q;
			endcase
		end
		if (cmd.rad_en) begin
			case (cmd.rad_op)
				R_MUL_OUT: begin
					p_q <= cot_mul_ph * cot_out_q;
					ysq_q <= 17'(y_q * y_q);
				end
				R_MUL_IN: p_q <= cot_mul_ph * cot_in_q;
				R_SCALE_OUT, R_SCALE_IN: r_q <= r_sat;
				R_SQ_OUT: ro2_q <= r_q * r_q;
				default: ri2_q <= r_q * r_q;
			endcase
		end
		if (cmd.capture) begin
			column <= 6'(x_q);
			inside_res <= ({15'b0, d2} < ro2_q) && ({15'b0, d2} > ri2_q) &&
				(yq < xr) && (yq > xl);
			last_column <= (x_inc == (NW+1)'(n_q));
			x_q <= XW'(x_inc);
		end
	end
endmodule

### hdl/annular_sector_row_mask.sv
// Top level of the annular sector row mask: sequencer plus datapath.
//
//  channel  dir  handshake      word
//  in_ch    in   valid/ready    two azimuth/elevation corners, row_number
//  out_ch   out  valid/ready    column, inside_res, last_column
//  cfg      in   cfg_we         cfg_index 0 post_height, 1 grid_width
//
// Setup per row: four cotangent divisions on one shared
// restoring divider (one quotient bit a cycle), then six radius steps.
// Then one word per column, held in the output register until taken;
// a stalled sink just holds it. The next row is taken only after the last
// column word leaves. Reset gives post_height 256, width 64.
module annular_sector_row_mask #(
	parameter int MAX_WIDTH = asrm_pkg::MAX_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	asrm_in_if.sink in_ch,
	asrm_out_if.source out_ch,
	input logic cfg_we,
	input logic cfg_index,
	input logic [asrm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import asrm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: accepts a row only when idle
	asrm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts(sts),
		.cmd(cmd)
	);

	// arithmetic and the output word register
	asrm_dpath #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.first_azimuth(in_ch.first_azimuth),
		.first_elevation(in_ch.first_elevation),
		.second_azimuth(in_ch.second_azimuth),
		.second_elevation(in_ch.second_elevation),
		.row_number(in_ch.row_number),
		.cmd(cmd),
		.sts(sts),
		.column(out_ch.column),
		.inside_res(out_ch.inside_res),
		.last_column(out_ch.last_column)
	);
endmodule

### test/asrm_row_checker.sv
// Checker for the annular sector row mask: predicts each row and compares column words.
`timescale 1ns / 100ps
module asrm_row_checker (
	input logic clk,
	input logic arst_n,
	asrm_in_if in_ch,
	asrm_out_if out_ch,
	input logic cfg_we,
	input logic cfg_index,
	input logic [asrm_pkg::CFG_DATA_W-1:0] cfg_data,
	output int fail_count,
	output int pending_words
);
	import asrm_pkg::*;

	typedef struct packed {
		logic [5:0] column;
		logic inside_res;
		logic last_column;
	} col_word_t;

	col_word_t expected_cols[$];
	longint unsigned cot_tab[90];
	logic [15:0] post_h;
	logic [6:0] grid_w;

	// Q30 rotation generator, then Q16 cotangents rounded
	initial begin
		longint unsigned c[46];
		longint unsigned s[46];
		longint unsigned cv;
		longint unsigned sv;
		c[0] = 64'd1073741824;
		s[0] = 0;
		for (int k = 0; k < 45; k++) begin
			c[k+1] = (c[k] * 64'd1073578288 - s[k] * 64'd18739379 + 64'd536870912) >> 30;
			s[k+1] = (s[k] * 64'd1073578288 + c[k] * 64'd18739379 + 64'd536870912) >> 30;
		end
		cot_tab[0] = 0;
		for (int k = 1; k < 90; k++) begin
			cv = (k <= 45) ? c[k] : s[90-k];
			sv = (k <= 45) ? s[k] : c[90-k];
			if (sv == 0)
				sv = 1;
			cot_tab[k] = ((cv << 16) + sv / 2) / sv;
		end
	end

	function automatic int clamp_deg(int v, int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic longint signed slope_of(int a);
		if (a < 90)
			return longint'(cot_tab[a]);
		if (a == 90)
			return 0;
		return -longint'(cot_tab[180-a]);
	endfunction

	function automatic longint unsigned radius_q8(longint unsigned cot);
		longint unsigned r;
		r = (longint'(post_h) * cot * 10 + 64'd32768) >> 16;
		return (r > 64'hFFFFFF) ? 64'hFFFFFF : r;
	endfunction

	task automatic predict_row(int a1r, int e1r, int a2r, int e2r, int row);
		int a1, e1, a2, e2, n;
		longint unsigned ro, ri, ro2, ri2, d2;
		longint signed right_s, left_s, y, yq;
		col_word_t w;
		a1 = clamp_deg(a1r, 179);
		e1 = clamp_deg(e1r, 89);
		a2 = clamp_deg(a2r, 179);
		e2 = clamp_deg(e2r, 89);
		ro = radius_q8(cot_tab[(e1 < e2) ? e1 : e2]);
		ri = radius_q8(cot_tab[(e1 < e2) ? e2 : e1]);
		ro2 = ro * ro;
		ri2 = ri * ri;
		right_s = slope_of((a1 < a2) ? a1 : a2);
		left_s = slope_of((a1 < a2) ? a2 : a1);
		n = (grid_w > 64) ? 64 : grid_w;
		y = longint'(row) - n;
		for (int x = 0; x < n; x++) begin
			d2 = longint'(x * x + y * y) << 16;
			yq = y * 65536;
			w.column = x[5:0];
			w.inside_res = d2 < ro2 && d2 > ri2 && yq < x * right_s && yq > x * left_s;
			w.last_column = (x + 1 == n);
			expected_cols.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		col_word_t exp_w;
		if (!arst_n) begin
			post_h <= POST_HEIGHT_RST;
			grid_w <= GRID_WIDTH_RST;
			fail_count <= 0;
			pending_words <= 0;
			expected_cols.delete();
		end else begin
			if (in_ch.valid && in_ch.ready)
				predict_row(in_ch.first_azimuth, in_ch.first_elevation,
					in_ch.second_azimuth, in_ch.second_elevation, in_ch.row_number);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_cols.size() == 0) begin
					$display("%0t: unexpected word column=%0d inside=%0b last=%0b", $time,
						out_ch.column, out_ch.inside_res, out_ch.last_column);
					fail_count <= fail_count + 1;
				end else begin
					exp_w = expected_cols.pop_front();
					if (exp_w.column !== out_ch.column ||
						exp_w.inside_res !== out_ch.inside_res ||
						exp_w.last_column !== out_ch.last_column) begin
						$display("%0t: expected col=%0d in=%0b last=%0b, got col=%0d in=%0b last=%0b",
							$time, exp_w.column, exp_w.inside_res, exp_w.last_column,
							out_ch.column, out_ch.inside_res, out_ch.last_column);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_words <= expected_cols.size();
			if (cfg_we) begin
				if (cfg_index == CFG_POST_HEIGHT)
					post_h <= cfg_data;
				else
					grid_w <= cfg_data[6:0];
			end
		end
	end
endmodule

### test/annular_sector_row_mask_tb.sv
// Testbench top for the annular sector row mask: stimulus, flow control, verdict.
`timescale 1ns / 100ps
module annular_sector_row_mask_tb;
	import asrm_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int fail_count;
	int pending_words;
	int src_idle_pct;   // chance the sender idles per cycle
	int snk_stall_pct;  // chance the receiver stalls per cycle
	bit hold_off;       // long receiver hold-off in progress

	asrm_in_if in_ch();
	asrm_out_if out_ch();

	annular_sector_row_mask dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	asrm_row_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_words(pending_words)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Receiver: random stalls, or fully held off during the pressure stretch
	always @(negedge clk) begin
		out_ch.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
	end

	// Counted receiver hold-off so the output word waits and in_ch stalls
	task automatic long_hold_off(int cycles);
		hold_off = 1'b1;
		repeat (cycles) @(negedge clk);
		hold_off = 1'b0;
	endtask

	// Drive one row request; holds until the block takes it
	task automatic send_row(logic [7:0] a1, logic [6:0] e1, logic [7:0] a2,
		logic [6:0] e2, logic [7:0] row);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.first_azimuth <= a1;
		in_ch.first_elevation <= e1;
		in_ch.second_azimuth <= a2;
		in_ch.second_elevation <= e2;
		in_ch.row_number <= row;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	// Drain everything, let the setup pipeline settle, then write a register
	task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
		while (pending_words != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly in-range sectors, a share of clamped or degenerate fields
	task automatic send_random_row();
		logic [7:0] a1, a2, row;
		logic [6:0] e1, e2;
		if ($urandom_range(9) == 0) begin
			a1 = 8'($urandom); a2 = 8'($urandom); e1 = 7'($urandom); e2 = 7'($urandom);
		end else begin
			a1 = 8'($urandom_range(179, 1)); a2 = 8'($urandom_range(179, 1));
			e1 = 7'($urandom_range(89, 1)); e2 = 7'($urandom_range(89, 1));
		end
		row = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(70));
		send_row(a1, e1, a2, e2, row);
	endtask

	initial begin
		int phase_pct[4][2] = '{'{0, 0}, '{59, 0}, '{0, 59}, '{24, 24}};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_POST_HEIGHT;
		cfg_data = '0;
		hold_off = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		in_ch.valid = 1'b0;
		in_ch.first_azimuth = '0;
		in_ch.first_elevation = '0;
		in_ch.second_azimuth = '0;
		in_ch.second_elevation = '0;
		in_ch.row_number = '0;
		out_ch.ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, clamping, degenerate sectors, at reset config
		send_row(8'd45, 7'd20, 8'd135, 7'd60, 8'd40);
		send_row(8'd1, 7'd1, 8'd179, 7'd89, 8'd0);
		send_row(8'd179, 7'd89, 8'd1, 7'd1, 8'd255);
		send_row(8'd0, 7'd0, 8'd255, 7'd127, 8'd30);   // clamped fields
		send_row(8'd60, 7'd30, 8'd120, 7'd30, 8'd50);  // equal elevations
		send_row(8'd90, 7'd10, 8'd90, 7'd50, 8'd50);   // equal azimuths
		send_row(8'd90, 7'd5, 8'd30, 7'd70, 8'd64);
		send_row(8'd170, 7'd3, 8'd10, 7'd45, 8'd63);
		send_row(8'hAA, 7'h55, 8'h55, 7'h2A, 8'hA5);
		write_reg(CFG_POST_HEIGHT, 16'd0);             // zero post height
		send_row(8'd30, 7'd10, 8'd150, 7'd80, 8'd40);
		write_reg(CFG_POST_HEIGHT, 16'hFFFF);          // saturated radius
		send_row(8'd30, 7'd1, 8'd150, 7'd2, 8'd40);
		write_reg(CFG_GRID_WIDTH, 16'd0);              // zero width: no words
		send_row(8'd30, 7'd10, 8'd150, 7'd80, 8'd40);
		write_reg(CFG_GRID_WIDTH, 16'd127);            // above max width
		send_row(8'd30, 7'd10, 8'd150, 7'd80, 8'd40);
		write_reg(CFG_GRID_WIDTH, 16'd13);             // not a multiple of eight
		write_reg(CFG_POST_HEIGHT, 16'd1);
		send_row(8'd45, 7'd2, 8'd135, 7'd80, 8'd10);

		// Random: four settings, each run through all idling phases
		for (int cfg = 0; cfg < 4; cfg++) begin
			case (cfg)
				0: begin
					write_reg(CFG_GRID_WIDTH, 16'd8);
					write_reg(CFG_POST_HEIGHT, 16'd1280);
				end
				1: begin
					write_reg(CFG_GRID_WIDTH, 16'd16);
					write_reg(CFG_POST_HEIGHT, 16'd300);
				end
				2: begin
					write_reg(CFG_GRID_WIDTH, 16'd64);
					write_reg(CFG_POST_HEIGHT, 16'd256);
				end
				default: begin
					write_reg(CFG_GRID_WIDTH, 16'($urandom_range(64, 1)));
					write_reg(CFG_POST_HEIGHT, 16'($urandom));
				end
			endcase
			for (int ph = 0; ph < 4; ph++) begin
				src_idle_pct = phase_pct[ph][0];
				snk_stall_pct = phase_pct[ph][1];
				if (cfg == 1 && ph == 0) begin
					fork
						long_hold_off(600);
						repeat (4) send_random_row();
					join
				end
				repeat ((cfg == 2) ? 20 : 25) send_random_row();
			end
		end
		src_idle_pct = 0;
		snk_stall_pct = 0;

		while (pending_words != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
